### src/bblru_pkg.sv
// bblru_pkg: shared types, field widths and codes of the byte budget lru cache policy unit
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package bblru_pkg;

    localparam int MODE_W      = 2;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 40;
    localparam int BYTES_W     = 48;
    localparam int CNT_OUT_W   = 5;
    localparam int STAT_W      = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 264;
    localparam int OUT_TUSER_W = 1;
    localparam int OP_W        = 2;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RST = 48'd1073741824;

    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [OP_W-1:0]   t_op;

    localparam t_mode MODE_LOOKUP = 2'd0;
    localparam t_mode MODE_INSERT = 2'd1;
    localparam t_mode MODE_PROBE  = 2'd2;
    localparam t_mode MODE_CLEAR  = 2'd3;

    // walk operations over the tag ram
    localparam t_op OP_SEARCH   = 2'd0;
    localparam t_op OP_PROMOTE  = 2'd1;
    localparam t_op OP_FIND_LRU = 2'd2;
    localparam t_op OP_AGE      = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic walk_start;
        t_op  walk_op;
        logic hit_inc;
        logic miss_inc;
        logic evict;
        logic insert;
        logic emit;
        logic emit_ev;
    } t_cmd;

    typedef struct packed {
        logic  walk_done;
        logic  hit;
        logic  count_zero;
        logic  count_full;
        logic  over_budget;
        logic  out_free;
        t_mode mode;
    } t_stat;

endpackage

`default_nettype wire

### src/byte_budget_lru_cache_policy_unit.sv
// byte_budget_lru_cache_policy_unit: top level of the size-weighted lru tag store
// depends on bblru_pkg, bblru_ctrl, bblru_dp and bblru_ram
//
// One request is taken at a time and each walk reads the ENTRIES-word tag ram through its
// single read port, one entry a cycle. A lookup or insert hit promotes the entry with a
// second walk; an insert of a new key runs a find-lru walk for each entry it evicts, then an
// ageing walk, before it writes the key. Each eviction is its own result transfer with tlast
// low; the final result has tlast high. A new request can be taken while the last result
// of the previous one still waits on the master side. The user must write the byte budget
// with i_cfg_wr_en only while the unit is idle; the block itself does not enforce this.
`default_nettype none

module byte_budget_lru_cache_policy_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [bblru_pkg::BYTES_W-1:0]         i_cfg_wr_data,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // key [31:0], item_bytes [71:32]
    input  wire logic [bblru_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // mode [1:0]
    input  wire logic [bblru_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // hit [0], found_bytes [40:1], evicted_key [72:41], evicted_bytes [112:73],
    // total_bytes [160:113], entry_count [165:161], hit_count [197:166],
    // miss_count [229:198], eviction_count [261:230], zero fill [263:262]
    output logic [bblru_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // is_eviction [0]
    output logic [bblru_pkg::OUT_TUSER_W-1:0]          m_axis_tuser,
    output logic                                       m_axis_tlast
);

    bblru_pkg::t_cmd  cmd;
    bblru_pkg::t_stat stat;

    bblru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_mode   (s_axis_tuser),
        .i_stat     (stat),
        .o_ready    (s_axis_tready),
        .o_cmd      (cmd)
    );

    bblru_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser),
        .o_m_tlast     (m_axis_tlast),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    a_no_evict_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> !stat.count_zero)
        else $error("eviction from an empty store");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |-> !stat.count_full)
        else $error("insert into a full store");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result register overwritten before its transfer");

    a_walk_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_start |=> !stat.walk_done)
        else $error("walk finished one cycle after start");

endmodule

`default_nettype wire

### src/bblru_ram.sv
// bblru_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module bblru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/bblru_ctrl.sv
// bblru_ctrl: request sequencer for lookup, probe, insert with eviction and clear
// depends on bblru_pkg for command, status and code definitions
`default_nettype none

module bblru_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire bblru_pkg::t_mode       i_s_mode,
    input  wire bblru_pkg::t_stat       i_stat,
    output logic                        o_ready,
    output bblru_pkg::t_cmd             o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_SEARCH  = 4'd2;
    localparam logic [3:0] S_DECIDE  = 4'd3;
    localparam logic [3:0] S_PROMOTE = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_LRU     = 4'd6;
    localparam logic [3:0] S_EVICT   = 4'd7;
    localparam logic [3:0] S_EMIT_EV = 4'd8;
    localparam logic [3:0] S_AGE     = 4'd9;
    localparam logic [3:0] S_INSERT  = 4'd10;
    localparam logic [3:0] S_FINAL   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_s_mode == bblru_pkg::MODE_CLEAR) begin
                        n_state = S_CLEAR;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        o_cmd.walk_op    = bblru_pkg::OP_SEARCH;
                        n_state          = S_SEARCH;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_FINAL;
            end
            S_SEARCH: begin
                if (i_stat.walk_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.mode == bblru_pkg::MODE_LOOKUP) begin
                    o_cmd.hit_inc  = i_stat.hit;
                    o_cmd.miss_inc = !i_stat.hit;
                end
                if (i_stat.hit && (i_stat.mode inside {bblru_pkg::MODE_LOOKUP,
                                                       bblru_pkg::MODE_INSERT})) begin
                    o_cmd.walk_start = 1'b1;
                    o_cmd.walk_op    = bblru_pkg::OP_PROMOTE;
                    n_state          = S_PROMOTE;
                end else if (!i_stat.hit && i_stat.mode == bblru_pkg::MODE_INSERT) begin
                    n_state = S_CHECK;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_PROMOTE: begin
                if (i_stat.walk_done) begin
                    n_state = S_FINAL;
                end
            end
            S_CHECK: begin
                o_cmd.walk_start = 1'b1;
                if ((!i_stat.count_zero && i_stat.over_budget) || i_stat.count_full) begin
                    o_cmd.walk_op = bblru_pkg::OP_FIND_LRU;
                    n_state       = S_LRU;
                end else begin
                    o_cmd.walk_op = bblru_pkg::OP_AGE;
                    n_state       = S_AGE;
                end
            end
            S_LRU: begin
                if (i_stat.walk_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_EMIT_EV;
            end
            S_EMIT_EV: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_ev = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_AGE: begin
                if (i_stat.walk_done) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_FINAL;
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/bblru_dp.sv
// bblru_dp: tag ram with walk engine, valid bits, byte total, counters and result register
// depends on bblru_pkg and bblru_ram
`default_nettype none

module bblru_dp #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [bblru_pkg::BYTES_W-1:0]          i_cfg_wr_data,
    input  wire logic [bblru_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    input  wire bblru_pkg::t_mode                       i_s_tuser,
    input  wire logic                                   i_m_tready,
    output logic                                        o_m_tvalid,
    output logic [bblru_pkg::OUT_TDATA_W-1:0]           o_m_tdata,
    output logic [bblru_pkg::OUT_TUSER_W-1:0]           o_m_tuser,
    output logic                                        o_m_tlast,
    input  wire bblru_pkg::t_cmd                        i_cmd,
    output bblru_pkg::t_stat                            o_stat
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SIZE_W = bblru_pkg::SIZE_W;
    localparam int WORD_W = KEY_BITS + SIZE_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // stored request
    bblru_pkg::t_mode              r_mode;
    logic [KEY_BITS-1:0]           r_key;
    logic [SIZE_W-1:0]             r_size;

    // store state
    logic [bblru_pkg::BYTES_W-1:0] r_max;
    logic [ENTRIES-1:0]            r_valid;
    logic [bblru_pkg::BYTES_W-1:0] r_bytes;
    logic [CNT_W-1:0]              r_count;
    logic [bblru_pkg::STAT_W-1:0]  r_hits;
    logic [bblru_pkg::STAT_W-1:0]  r_misses;
    logic [bblru_pkg::STAT_W-1:0]  r_evicts;

    // walk engine
    logic                          r_walk;
    bblru_pkg::t_op                r_op;
    logic [IDX_W-1:0]              r_ptr;
    logic                          r_pv;
    logic [IDX_W-1:0]              r_pidx;

    // walk results
    logic                          r_hit;
    logic [IDX_W-1:0]              r_hidx;
    logic [SIZE_W-1:0]             r_hsize;
    logic [IDX_W-1:0]              r_hrank;
    logic [IDX_W-1:0]              r_eidx;
    logic [KEY_BITS-1:0]           r_etag;
    logic [SIZE_W-1:0]             r_esize;
    logic [IDX_W-1:0]              r_fidx;

    // result register
    logic                          r_out_valid;
    logic                          r_o_hit;
    logic [SIZE_W-1:0]             r_o_found;
    logic                          r_o_ev;
    logic [bblru_pkg::KEY_W-1:0]   r_o_ekey;
    logic [SIZE_W-1:0]             r_o_ebytes;
    logic [bblru_pkg::BYTES_W-1:0] r_o_total;
    logic [bblru_pkg::CNT_OUT_W-1:0] r_o_count;
    logic [bblru_pkg::STAT_W-1:0]  r_o_hits;
    logic [bblru_pkg::STAT_W-1:0]  r_o_misses;
    logic [bblru_pkg::STAT_W-1:0]  r_o_evicts;
    logic                          r_o_last;

    logic [WORD_W-1:0]             w_rdata;
    logic [KEY_BITS-1:0]           w_tag;
    logic [SIZE_W-1:0]             w_size;
    logic [IDX_W-1:0]              w_rank;
    logic [IDX_W-1:0]              w_rank_inc;
    logic [IDX_W-1:0]              w_lru_rank;
    logic                          w_pvalid;
    logic                          w_tag_hit;
    logic                          w_lru_hit;
    logic                          w_pwe;
    logic [WORD_W-1:0]             w_pwdata;
    logic                          w_we;
    logic [IDX_W-1:0]              w_waddr;
    logic [WORD_W-1:0]             w_wdata;
    logic [bblru_pkg::BYTES_W:0]   w_need;

    bblru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    assign w_tag      = w_rdata[WORD_W-1 -: KEY_BITS];
    assign w_size     = w_rdata[IDX_W +: SIZE_W];
    assign w_rank     = w_rdata[IDX_W-1:0];
    assign w_rank_inc = w_rank + IDX_W'(1);
    assign w_lru_rank = IDX_W'(r_count - CNT_W'(1));
    assign w_pvalid   = r_valid[r_pidx];
    assign w_tag_hit  = w_pvalid && (w_tag == r_key);
    assign w_lru_hit  = w_pvalid && (w_rank == w_lru_rank);

    always_comb begin
        w_pwe    = 1'b0;
        w_pwdata = {w_tag, w_size, w_rank_inc};
        case (r_op)
            bblru_pkg::OP_PROMOTE: begin
                if (r_pidx == r_hidx) begin
                    w_pwe    = 1'b1;
                    w_pwdata = {w_tag, w_size, IDX_W'(0)};
                end else if (w_pvalid && (w_rank < r_hrank)) begin
                    w_pwe = 1'b1;
                end
            end
            bblru_pkg::OP_AGE: begin
                w_pwe = w_pvalid;
            end
            default: begin
                w_pwe = 1'b0;
            end
        endcase
    end

    assign w_we    = (r_pv && w_pwe) || i_cmd.insert;
    assign w_waddr = i_cmd.insert ? r_fidx : r_pidx;
    assign w_wdata = i_cmd.insert ? {r_key, r_size, IDX_W'(0)} : w_pwdata;

    assign w_need = {1'b0, r_bytes} + (bblru_pkg::BYTES_W + 1)'(r_size);

    assign o_stat.walk_done   = r_pv && (r_pidx == LAST_IDX);
    assign o_stat.hit         = r_hit;
    assign o_stat.count_zero  = (r_count == CNT_W'(0));
    assign o_stat.count_full  = (r_count == CNT_W'(ENTRIES));
    assign o_stat.over_budget = (w_need > {1'b0, r_max});
    assign o_stat.out_free    = !r_out_valid || i_m_tready;
    assign o_stat.mode        = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= bblru_pkg::MAX_BYTES_RST;
            r_valid     <= '0;
            r_bytes     <= '0;
            r_count     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_walk      <= 1'b0;
            r_op        <= bblru_pkg::OP_SEARCH;
            r_ptr       <= '0;
            r_pv        <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (i_cmd.walk_start) begin
                r_walk <= 1'b1;
                r_op   <= i_cmd.walk_op;
                r_ptr  <= '0;
            end else if (r_walk) begin
                r_ptr <= r_ptr + IDX_W'(1);
                if (r_ptr == LAST_IDX) begin
                    r_walk <= 1'b0;
                end
            end
            r_pv <= r_walk;
            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_pv && r_op == bblru_pkg::OP_SEARCH && w_tag_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_bytes <= '0;
                r_count <= '0;
            end
            if (i_cmd.evict) begin
                r_valid[r_eidx] <= 1'b0;
                r_bytes         <= r_bytes - bblru_pkg::BYTES_W'(r_esize);
                r_count         <= r_count - CNT_W'(1);
                r_evicts        <= r_evicts + 32'd1;
            end
            if (i_cmd.insert) begin
                r_valid[r_fidx] <= 1'b1;
                r_bytes         <= r_bytes + bblru_pkg::BYTES_W'(r_size);
                r_count         <= r_count + CNT_W'(1);
            end
            if (i_cmd.hit_inc) begin
                r_hits <= r_hits + 32'd1;
            end
            if (i_cmd.miss_inc) begin
                r_misses <= r_misses + 32'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_s_tuser;
            r_key  <= KEY_BITS'(i_s_tdata[bblru_pkg::KEY_W-1:0]);
            r_size <= i_s_tdata[bblru_pkg::KEY_W +: SIZE_W];
        end
        r_pidx <= r_ptr;
        if (r_pv) begin
            if (r_op == bblru_pkg::OP_SEARCH && w_tag_hit) begin
                r_hidx  <= r_pidx;
                r_hsize <= w_size;
                r_hrank <= w_rank;
            end
            if (r_op == bblru_pkg::OP_FIND_LRU && w_lru_hit) begin
                r_eidx  <= r_pidx;
                r_etag  <= w_tag;
                r_esize <= w_size;
            end
            if (r_op == bblru_pkg::OP_AGE && !w_pvalid) begin
                r_fidx <= r_pidx;
            end
        end
        if (i_cmd.emit) begin
            r_o_hit    <= !i_cmd.emit_ev && r_hit;
            r_o_found  <= (!i_cmd.emit_ev && r_hit) ? r_hsize : '0;
            r_o_ev     <= i_cmd.emit_ev;
            r_o_ekey   <= i_cmd.emit_ev ? bblru_pkg::KEY_W'(r_etag) : '0;
            r_o_ebytes <= i_cmd.emit_ev ? r_esize : '0;
            r_o_total  <= r_bytes;
            r_o_count  <= bblru_pkg::CNT_OUT_W'(r_count);
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
            r_o_evicts <= r_evicts;
            r_o_last   <= !i_cmd.emit_ev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_o_evicts, r_o_misses, r_o_hits, r_o_count, r_o_total,
                         r_o_ebytes, r_o_ekey, r_o_found, r_o_hit};
    assign o_m_tuser  = r_o_ev;
    assign o_m_tlast  = r_o_last;

endmodule

`default_nettype wire

### sim/byte_budget_lru_cache_policy_unit_test.sv
// byte_budget_lru_cache_policy_unit_test: self-checking bench for the byte budget lru tag store
// depends on bblru_pkg and byte_budget_lru_cache_policy_unit; drives requests over the slave
// stream, predicts every result transfer and checks each one on the master stream
`timescale 1ns / 100ps

module byte_budget_lru_cache_policy_unit_test;
    import bblru_pkg::*;

    localparam int TAG_SLOTS     = 16;
    localparam int KEY_POOL_SIZE = 20;
    localparam int SETTLE_CYCLES = 48;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int MAX_PRINTED   = 100;

    localparam logic [BYTES_W-1:0] BUDGET_MAX = {BYTES_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_MAX   = {SIZE_W{1'b1}};

    typedef struct packed {
        logic               hit;
        logic [SIZE_W-1:0]  found;
        logic               is_ev;
        logic [KEY_W-1:0]   ev_key;
        logic [SIZE_W-1:0]  ev_bytes;
        logic [BYTES_W-1:0] total;
        logic [4:0]         count;
        logic [STAT_W-1:0]  hits;
        logic [STAT_W-1:0]  misses;
        logic [STAT_W-1:0]  evicts;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_HOLD} t_rdy_style;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [BYTES_W-1:0]     i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [MODE_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    // cache model state
    logic [KEY_W-1:0]   tag_mem   [TAG_SLOTS];
    logic [SIZE_W-1:0]  size_mem  [TAG_SLOTS];
    logic               valid_mem [TAG_SLOTS];
    int unsigned        rank_mem  [TAG_SLOTS];
    logic [BYTES_W-1:0] bytes_held = '0;
    logic [STAT_W-1:0]  hit_total = '0;
    logic [STAT_W-1:0]  miss_total = '0;
    logic [STAT_W-1:0]  evict_total = '0;
    logic [BYTES_W-1:0] byte_budget = MAX_BYTES_RST;

    t_result     expected_results[$];
    int          err_count = 0;
    int          burst_left = 0;
    logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];
    t_rdy_style  rdy_style = RDY_ALWAYS;
    int          rdy_left = 0;

    byte_budget_lru_cache_policy_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- cache model

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < TAG_SLOTS; i++)
            if (valid_mem[i]) n++;
        return n;
    endfunction

    function automatic void queue_result(logic hit, logic [SIZE_W-1:0] found, logic ev,
                                         logic [KEY_W-1:0] ekey, logic [SIZE_W-1:0] ebytes,
                                         logic last);
        t_result r;
        r.hit      = hit;
        r.found    = found;
        r.is_ev    = ev;
        r.ev_key   = ekey;
        r.ev_bytes = ebytes;
        r.total    = bytes_held;
        r.count    = 5'(live_entries());
        r.hits     = hit_total;
        r.misses   = miss_total;
        r.evicts   = evict_total;
        r.last     = last;
        expected_results.push_back(r);
    endfunction

    function automatic void make_most_recent(int idx);
        int unsigned r;
        r = rank_mem[idx];
        for (int i = 0; i < TAG_SLOTS; i++)
            if (valid_mem[i] && rank_mem[i] < r) rank_mem[i]++;
        rank_mem[idx] = 0;
    endfunction

    function automatic void evict_oldest();
        int unsigned n;
        n = live_entries();
        for (int i = 0; i < TAG_SLOTS; i++) begin
            if (valid_mem[i] && rank_mem[i] == n - 1) begin
                valid_mem[i] = 1'b0;
                bytes_held   = bytes_held - BYTES_W'(size_mem[i]);
                evict_total++;
                queue_result(1'b0, '0, 1'b1, tag_mem[i], size_mem[i], 1'b0);
                return;
            end
        end
    endfunction

    function automatic void predict_request(t_mode mode, logic [KEY_W-1:0] key,
                                            logic [SIZE_W-1:0] size);
        int   idx;
        logic placed;
        idx = -1;
        placed = 1'b0;
        if (mode == MODE_CLEAR) begin
            for (int i = 0; i < TAG_SLOTS; i++) valid_mem[i] = 1'b0;
            bytes_held = '0;
            queue_result(1'b0, '0, 1'b0, '0, '0, 1'b1);
            return;
        end
        for (int i = 0; i < TAG_SLOTS; i++)
            if (idx < 0 && valid_mem[i] && tag_mem[i] == key) idx = i;
        if (mode == MODE_LOOKUP || mode == MODE_PROBE) begin
            if (idx >= 0) begin
                if (mode == MODE_LOOKUP) begin
                    make_most_recent(idx);
                    hit_total++;
                end
                queue_result(1'b1, size_mem[idx], 1'b0, '0, '0, 1'b1);
            end else begin
                if (mode == MODE_LOOKUP) miss_total++;
                queue_result(1'b0, '0, 1'b0, '0, '0, 1'b1);
            end
            return;
        end
        if (idx >= 0) begin
            make_most_recent(idx);
            queue_result(1'b1, size_mem[idx], 1'b0, '0, '0, 1'b1);
            return;
        end
        while (live_entries() > 0 && 64'(bytes_held) + 64'(size) > 64'(byte_budget))
            evict_oldest();
        if (live_entries() >= TAG_SLOTS) evict_oldest();
        for (int i = 0; i < TAG_SLOTS; i++) begin
            if (!placed && !valid_mem[i]) begin
                for (int j = 0; j < TAG_SLOTS; j++)
                    if (valid_mem[j]) rank_mem[j]++;
                valid_mem[i] = 1'b1;
                tag_mem[i]   = key;
                size_mem[i]  = size;
                rank_mem[i]  = 0;
                bytes_held   = bytes_held + BYTES_W'(size);
                placed       = 1'b1;
            end
        end
        queue_result(1'b0, '0, 1'b0, '0, '0, 1'b1);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTED) $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit      = m_axis_tdata[0];
            got.found    = m_axis_tdata[40:1];
            got.ev_key   = m_axis_tdata[72:41];
            got.ev_bytes = m_axis_tdata[112:73];
            got.total    = m_axis_tdata[160:113];
            got.count    = m_axis_tdata[165:161];
            got.hits     = m_axis_tdata[197:166];
            got.misses   = m_axis_tdata[229:198];
            got.evicts   = m_axis_tdata[261:230];
            got.is_ev    = m_axis_tuser[0];
            got.last     = m_axis_tlast;
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                compare_field("hit", got.hit, want.hit);
                compare_field("found_bytes", got.found, want.found);
                compare_field("is_eviction", got.is_ev, want.is_ev);
                compare_field("evicted_key", got.ev_key, want.ev_key);
                compare_field("evicted_bytes", got.ev_bytes, want.ev_bytes);
                compare_field("total_bytes", got.total, want.total);
                compare_field("entry_count", got.count, want.count);
                compare_field("hit_count", got.hits, want.hits);
                compare_field("miss_count", got.misses, want.misses);
                compare_field("eviction_count", got.evicts, want.evicts);
                compare_field("tlast", got.last, want.last);
            end
        end
    end

    // receiver back-pressure in phases of random style and length
    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_style <= t_rdy_style'($urandom_range(0, 3));
            rdy_left  <= $urandom_range(8, 80);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        case (rdy_style)
            RDY_ALWAYS: m_axis_tready <= 1'b1;
            RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    m_axis_tready <= (rdy_left < 4);
        endcase
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_request(t_mode mode, logic [KEY_W-1:0] key, logic [SIZE_W-1:0] size);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {size, key};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(mode, key, size);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [BYTES_W-1:0] value);
        drain_and_settle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        byte_budget = value;
    endtask

    // every mode, zero size, present key on insert, oversized item, clear
    task automatic test_basic_modes();
        send_request(MODE_LOOKUP, 32'h0, '0);
        send_request(MODE_PROBE, 32'hFFFF_FFFF, SIZE_MAX);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, '0);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, '0);
        send_request(MODE_INSERT, 32'h0, 40'd1000);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 40'd5);
        send_request(MODE_PROBE, 32'h0, '0);
        send_request(MODE_INSERT, 32'h1234_5678, SIZE_MAX);
        send_request(MODE_CLEAR, 32'h1234_5678, '0);
    endtask

    task automatic test_zero_budget();
        write_budget('0);
        send_request(MODE_INSERT, 32'hA5A5_0001, '0);
        send_request(MODE_INSERT, 32'h5A5A_0002, 40'd1);
        send_request(MODE_LOOKUP, 32'hA5A5_0001, '0);
    endtask

    // fill the table under an unlimited budget until the oldest entry falls out
    task automatic test_table_full();
        write_budget(BUDGET_MAX);
        for (int i = 0; i < TAG_SLOTS; i++)
            send_request(MODE_INSERT, 32'hC000_0000 + i, (i % 4 == 0) ? SIZE_MAX : 40'(i * 7));
    endtask

    task automatic test_random_mix(logic [BYTES_W-1:0] budget, logic [SIZE_W-1:0] size_cap,
                                   int count);
        int          pick;
        t_mode       mode;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [63:0] r;
        write_budget(budget);
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      mode = MODE_INSERT;
            else if (pick < 75) mode = MODE_LOOKUP;
            else if (pick < 95) mode = MODE_PROBE;
            else                mode = MODE_CLEAR;
            key = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                               : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            r = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) size = r[SIZE_W-1:0];
            else                           size = SIZE_W'(r % (64'(size_cap) + 64'd1));
            send_request(mode, key, size);
        end
    endtask

    initial begin
        for (int i = 0; i < TAG_SLOTS; i++) begin
            valid_mem[i] = 1'b0;
            rank_mem[i]  = 0;
            tag_mem[i]   = '0;
            size_mem[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_modes();
        test_zero_budget();
        test_table_full();
        test_random_mix(48'd4096, 40'd1500, 30);
        test_random_mix(BUDGET_MAX, 40'd255, 30);
        test_random_mix(MAX_BYTES_RST, 40'h0080_0000_0000 >> 8, 30);
        test_random_mix('0, 40'd64, 20);
        test_random_mix(BYTES_W'({$urandom, $urandom}), SIZE_MAX, 20);
        drain_and_settle();

        if (expected_results.size() != 0) report_mismatch("results still outstanding");
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### byte_budget_lru_cache_policy_unit.f
src/bblru_pkg.sv
src/bblru_ram.sv
src/bblru_ctrl.sv
src/bblru_dp.sv
src/byte_budget_lru_cache_policy_unit.sv
sim/byte_budget_lru_cache_policy_unit_test.sv
